// ===== design/uhb_pkg.sv =====
// Shared types, constants and lookup functions for the UDP stream header builder.
`timescale 1ns / 1ps
package uhb_pkg;

   localparam int HEADER_BYTES = 42;
   localparam int INDEX_W      = 6;
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(HEADER_BYTES - 1);

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [1:0]  STREAM_DEBUG  = 2'd2;
   localparam logic [7:0]  MCAST_MASK    = 8'hF8;
   localparam logic [7:0]  MCAST_PREFIX  = 8'hE8;
   localparam logic [7:0]  MCAST_O2_MASK = 8'h7F;
   localparam logic [31:0] BCAST_IP      = 32'hFFFF_FFFF;

   // Sum of the fixed 16-bit words of the IPv4 header (checksum field as zero).
   localparam logic [18:0] IP_FIXED_SUM  = 19'h180E8;

   typedef enum logic [1:0] {
      CSR_LOCAL_IP  = 2'd0,
      CSR_LOCAL_MAC = 2'd1,
      CSR_BUS_MODE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [31:0] local_ip;
      logic [47:0] local_mac;
      logic [2:0]  bus_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  stream_id;
      logic        build;
      logic [31:0] dest_ip;
      logic [15:0] peer_port;
      logic [47:0] peer_mac;
      logic [7:0]  enable;
   } job_type;

   typedef logic [HEADER_BYTES-1:0][7:0] hdr_type;

   function automatic logic [3:0] mode_nibble(input logic [2:0] mode);
      logic [3:0] n;
      unique case (mode)
         3'd0: n = 4'h1;
         3'd1: n = 4'h2;
         3'd2: n = 4'h3;
         3'd3: n = 4'h4;
         3'd4: n = 4'h5;
         3'd5: n = 4'h9;
         3'd6: n = 4'hB;
         default: n = 4'h0;
      endcase
      return n;
   endfunction

   function automatic logic [15:0] src_port(input logic [1:0] id);
      logic [15:0] p;
      unique case (id)
         2'd0: p = 16'hD000;
         2'd1: p = 16'hD400;
         2'd2: p = 16'h196E;
         default: p = 16'h0605;
      endcase
      return p;
   endfunction

endpackage

// ===== design/udp_stream_header_builder.sv =====
// Top level of the UDP stream header builder.
// A request word accepted into the input register is loaded into the output shift register
//   when the output is free.
// Throughput (rsp_tready high): a header run gives 42 words, one per cycle, set by the output
//   shift register; a disable-only request gives one word, so one may follow every cycle.
// Reset (synchronous, active high): clears the enable register, configuration and all valids.
`timescale 1ns / 1ps
module udp_stream_header_builder
   import uhb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request word: stream_id[1:0], stream_on[2], dest_ip[34:3], peer_port[50:35],
   // peer_mac[98:51], zero fill above
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result word: header_byte[7:0], byte_index[13:8], enable_register[21:14], zero fill above
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // result flag: header_valid[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   job_type job;
   hdr_type hdr;
   logic    job_valid;
   logic    take;

   // Configuration registers: local IP, local MAC, debug bus mode.
   uhb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Hold the accepted request and advance the enable register in request order;
   // the enable value travels with the job so every result word carries its own copy.
   uhb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .take       (take),
      .job_valid  (job_valid),
      .job        (job)
   );

   // Build all 42 header bytes from the held job in one pass.
   uhb_hdr_build u_hdr_build (
      .cfg_job (job),
      .cfg     (cfg),
      .hdr     (hdr)
   );

   // Load the header when the output is empty or finishing its last word,
   // then shift one byte out per accepted word.
   uhb_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .hdr        (hdr),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/uhb_csr.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module uhb_csr
   import uhb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [31:0] local_ip_ff,  local_ip_in;
   logic [47:0] local_mac_ff, local_mac_in;
   logic [2:0]  bus_mode_ff,  bus_mode_in;
   logic        wr_en;
   csr_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_index_type'(csr_paddr[4:3]);

   always_comb begin
      local_ip_in  = local_ip_ff;
      local_mac_in = local_mac_ff;
      bus_mode_in  = bus_mode_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_LOCAL_IP:  local_ip_in  = csr_pwdata[31:0];
            CSR_LOCAL_MAC: local_mac_in = csr_pwdata[47:0];
            CSR_BUS_MODE:  bus_mode_in  = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_LOCAL_IP:  csr_prdata = {32'h0, local_ip_ff};
         CSR_LOCAL_MAC: csr_prdata = {16'h0, local_mac_ff};
         CSR_BUS_MODE:  csr_prdata = {61'h0, bus_mode_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= '0;
         local_mac_ff <= '0;
         bus_mode_ff  <= '0;
      end else begin
         local_ip_ff  <= local_ip_in;
         local_mac_ff <= local_mac_in;
         bus_mode_ff  <= bus_mode_in;
      end
   end

   assign cfg = '{local_ip: local_ip_ff, local_mac: local_mac_ff, bus_mode: bus_mode_ff};

endmodule

// ===== design/uhb_front.sv =====
// Input register and stream enable register update.
`timescale 1ns / 1ps
module uhb_front
   import uhb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cfg_type               cfg,
   input  logic                  take,
   output logic                  job_valid,
   output job_type               job
);

   logic       job_valid_ff, job_valid_in;
   job_type    job_ff, job_in;
   logic [7:0] enable_ff, enable_in;
   logic       accept;
   logic [1:0] id;
   logic       on;
   logic [7:0] id_mask;
   logic [7:0] built_en;

   assign req_tready = ~job_valid_ff | take;
   assign accept     = req_tvalid & req_tready;
   assign id         = req_tdata[1:0];
   assign on         = req_tdata[2];
   assign id_mask    = 8'b1 << id;

   always_comb begin
      built_en = enable_ff;
      if (id == STREAM_DEBUG) begin
         built_en[7:4] = mode_nibble(cfg.bus_mode);
      end
      built_en = built_en | id_mask;
   end

   always_comb begin
      job_in.stream_id = id;
      job_in.build     = on & (cfg.local_ip != '0);
      job_in.dest_ip   = req_tdata[34:3];
      job_in.peer_port = req_tdata[50:35];
      job_in.peer_mac  = req_tdata[98:51];
      job_in.enable    = job_in.build ? built_en : (enable_ff & ~id_mask);
      enable_in        = accept ? job_in.enable : enable_ff;
      if (accept) begin
         job_valid_in = 1'b1;
      end else if (take) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         enable_ff    <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         enable_ff    <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

// ===== design/uhb_hdr_build.sv =====
// Header assembly: MAC selection, template fill and IPv4 checksum.
`timescale 1ns / 1ps
module uhb_hdr_build
   import uhb_pkg::*;
(
   input  job_type cfg_job,
   input  cfg_type cfg,
   output hdr_type hdr
);

   logic [31:0] lip;
   logic [31:0] dip;
   logic [47:0] dmac;
   logic [18:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] cks;
   logic [15:0] sport;

   assign lip   = cfg.local_ip;
   assign dip   = cfg_job.dest_ip;
   assign sport = src_port(cfg_job.stream_id);

   // Destination MAC: multicast mapping, broadcast, else the given address.
   always_comb begin
      if ((dip[7:0] & MCAST_MASK) == MCAST_PREFIX) begin
         dmac = {dip[31:24], dip[23:16], dip[15:8] & MCAST_O2_MASK, 8'h5E, 8'h00, 8'h01};
      end else if (dip == BCAST_IP) begin
         dmac = '1;
      end else begin
         dmac = cfg_job.peer_mac;
      end
   end

   // Ones'-complement sum of the address words plus the fixed words.
   always_comb begin
      sum   = IP_FIXED_SUM
            + {3'b0, lip[7:0],   lip[15:8]}
            + {3'b0, lip[23:16], lip[31:24]}
            + {3'b0, dip[7:0],   dip[15:8]}
            + {3'b0, dip[23:16], dip[31:24]};
      fold1 = {1'b0, sum[15:0]} + {14'b0, sum[18:16]};
      fold2 = fold1[15:0] + {15'b0, fold1[16]};
      cks   = ~fold2;
   end

   always_comb begin
      hdr = '0;
      for (int i = 0; i < 6; i++) begin
         hdr[i]     = dmac[8*i +: 8];
         hdr[6 + i] = cfg.local_mac[8*i +: 8];
      end
      hdr[12] = 8'h08;
      hdr[14] = 8'h45;
      hdr[17] = 8'h1C;
      hdr[18] = 8'hBB;
      hdr[19] = 8'hBB;
      hdr[20] = 8'h40;
      hdr[22] = 8'h40;
      hdr[23] = 8'h11;
      hdr[24] = cks[15:8];
      hdr[25] = cks[7:0];
      for (int i = 0; i < 4; i++) begin
         hdr[26 + i] = lip[8*i +: 8];
         hdr[30 + i] = dip[8*i +: 8];
      end
      hdr[34] = sport[15:8];
      hdr[35] = sport[7:0];
      hdr[36] = cfg_job.peer_port[15:8];
      hdr[37] = cfg_job.peer_port[7:0];
      hdr[39] = 8'h08;
   end

endmodule

// ===== design/uhb_serial.sv =====
// Result register: shifts the built header out one byte per word.
`timescale 1ns / 1ps
module uhb_serial
   import uhb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   input  hdr_type               hdr,
   output logic                  take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic               run_ff,   run_in;
   hdr_type            bytes_ff, bytes_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               hv_ff,    hv_in;
   logic [7:0]         en_ff,    en_in;
   logic               fire;
   logic               last;

   assign last = ~hv_ff | (index_ff == LAST_INDEX);
   assign fire = run_ff & rsp_tready;
   assign take = job_valid & (~run_ff | (fire & last));

   always_comb begin
      run_in   = run_ff;
      bytes_in = bytes_ff;
      index_in = index_ff;
      hv_in    = hv_ff;
      en_in    = en_ff;
      if (take) begin
         run_in   = 1'b1;
         bytes_in = job.build ? hdr : '0;
         index_in = '0;
         hv_in    = job.build;
         en_in    = job.enable;
      end else if (fire) begin
         if (last) begin
            run_in = 1'b0;
         end else begin
            bytes_in = hdr_type'(bytes_ff >> 8);
            index_in = index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      index_ff <= index_in;
      hv_ff    <= hv_in;
      en_ff    <= en_in;
   end

   assign rsp_tvalid = run_ff;
   assign rsp_tdata  = {2'b00, en_ff, index_ff, bytes_ff[0]};
   assign rsp_tuser  = hv_ff;
   assign rsp_tlast  = last;

endmodule

// ===== design/uhb_checker.sv =====
// Port-level checks for the UDP stream header builder, bound to the top level.
`timescale 1ns / 1ps
module uhb_checker
   import uhb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // A disable-only word is a single word with a zero byte at offset zero.
   a_disable_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[13:8] == '0
         && rsp_tdata[7:0] == '0)
      else $error("malformed disable-only word");

   // Inside a header run the offset advances by one with no gap.
   a_run_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser
         && rsp_tdata[13:8] == $past(rsp_tdata[13:8]) + 1'b1)
      else $error("header run offset did not advance");

   // A header run ends exactly on its final byte.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast == (rsp_tdata[13:8] == LAST_INDEX))
      else $error("header run ended at wrong offset");

endmodule

bind udp_stream_header_builder uhb_checker u_uhb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/udp_stream_header_builder_tb.sv =====
// Self-checking testbench for the UDP stream header builder: directed and random requests.
`timescale 1ns / 1ps
module udp_stream_header_builder_tb;
   import uhb_pkg::*;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int DRAIN_CYCLES    = 50;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PRINT_LIMIT     = 50;
   // Register slot past the defined ones; writes there must leave the setup alone.
   localparam int CSR_SPARE_INDEX = 3;

   // Mode byte per bus mode index, entry 0 in the low byte.
   localparam logic [7:0][7:0] MODE_BYTES =
      {8'h00, 8'h0B, 8'h09, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01};
   // Fixed UDP source port per stream, stream 0 in the low half-word.
   localparam logic [3:0][15:0] SOURCE_PORTS = {16'h0605, 16'h196E, 16'hD400, 16'hD000};

   // One expected result word.
   typedef struct packed {
      logic [7:0] hbyte;
      logic [5:0] index;
      logic       hvalid;
      logic       last;
      logic [7:0] enables;
   } rsp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // stream_id[1:0], stream_on[2], dest_ip[34:3], peer_port[50:35], peer_mac[98:51]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // header_byte[7:0], byte_index[13:8], enable_register[21:14]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // header_valid[0]
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the block's setup and enable register.
   logic [31:0] own_ip = '0;
   logic [47:0] own_mac = '0;
   logic [2:0]  bus_mode = '0;
   logic [7:0]  enable_shadow = '0;

   rsp_word_type header_words[$];

   int cycle_count     = 0;
   int error_count     = 0;
   int requests_sent   = 0;
   int header_runs     = 0;
   int disable_words   = 0;
   int words_checked   = 0;
   int csr_writes      = 0;
   int rsp_hold_cycles = 0;

   udp_stream_header_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, header_words.size());
         $display("udp_stream_header_builder verification failed");
         $finish;
      end
   end

   // Count every mismatch; print only the first few so a broken block stays readable.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Gap length: mostly none, often short, now and then long.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // Work out the words one request causes and update the enable shadow.
   task automatic predict_request(input logic [1:0] sid, input logic on,
                                  input logic [31:0] dip, input logic [15:0] dport,
                                  input logic [47:0] dmac);
      hdr_type      h;
      logic [31:0]  sum;
      rsp_word_type w;
      int           i;
      if (!on || own_ip == '0) begin
         // Disable only: clear the stream's bit, one word with no header data.
         enable_shadow[sid] = 1'b0;
         w.hbyte   = 8'h00;
         w.index   = '0;
         w.hvalid  = 1'b0;
         w.last    = 1'b1;
         w.enables = enable_shadow;
         header_words.push_back(w);
         disable_words++;
      end else begin
         h = '0;
         h[12] = 8'h08;                 // EtherType IPv4, high byte
         h[14] = 8'h45;                 // version 4, header length 5
         h[17] = 8'h1C;                 // total length 28
         h[18] = 8'hBB;                 // identification
         h[19] = 8'hBB;
         h[20] = 8'h40;                 // don't fragment
         h[22] = 8'h40;                 // TTL 64
         h[23] = 8'h11;                 // protocol UDP
         h[39] = 8'h08;                 // UDP length 8
         for (i = 0; i < 6; i++)
            h[6 + i] = own_mac[8*i +: 8];
         for (i = 0; i < 4; i++) begin
            h[26 + i] = own_ip[8*i +: 8];
            h[30 + i] = dip[8*i +: 8];
         end
         // Destination MAC: multicast mapping, broadcast, or the given unicast MAC.
         if ((dip[7:0] & 8'hF8) == 8'hE8) begin
            h[0] = 8'h01;
            h[1] = 8'h00;
            h[2] = 8'h5E;
            h[3] = dip[15:8] & 8'h7F;
            h[4] = dip[23:16];
            h[5] = dip[31:24];
         end else if (dip == 32'hFFFF_FFFF) begin
            for (i = 0; i < 6; i++)
               h[i] = 8'hFF;
         end else begin
            for (i = 0; i < 6; i++)
               h[i] = dmac[8*i +: 8];
         end
         h[34] = SOURCE_PORTS[sid][15:8];
         h[35] = SOURCE_PORTS[sid][7:0];
         h[36] = dport[15:8];
         h[37] = dport[7:0];
         // Ones'-complement sum over the 20-byte IPv4 header, checksum field as zero.
         sum = '0;
         for (i = 0; i < 10; i++)
            sum += {16'h0, h[14 + 2*i], h[15 + 2*i]};
         sum = {16'h0, sum[31:16]} + {16'h0, sum[15:0]};
         sum = {16'h0, sum[31:16]} + {16'h0, sum[15:0]};
         h[24] = ~sum[15:8];
         h[25] = ~sum[7:0];
         if (sid == STREAM_DEBUG)
            enable_shadow[7:4] = MODE_BYTES[bus_mode][3:0];
         enable_shadow[sid] = 1'b1;
         for (i = 0; i < HEADER_BYTES; i++) begin
            w.hbyte   = h[i];
            w.index   = 6'(i);
            w.hvalid  = 1'b1;
            w.last    = (i == HEADER_BYTES - 1);
            w.enables = enable_shadow;
            header_words.push_back(w);
         end
         header_runs++;
      end
   endtask

   // Offer one request word after an optional gap and hold it until accepted.
   // Call right after a rising edge.
   task automatic send_request(input logic [1:0] sid, input logic on, input logic [31:0] dip,
                               input logic [15:0] dport, input logic [47:0] dmac,
                               input bit use_gap);
      int gap;
      gap = use_gap ? idle_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({dmac, dport, dip, on, sid});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_request(sid, on, dip, dport, dmac);
      requests_sent++;
   endtask

   task automatic send_random_request(input bit use_gap);
      logic [31:0] dip;
      int          r;
      dip = $urandom;
      r   = $urandom_range(0, 9);
      if (r < 3)
         dip[7:0] = 8'hE8 + 8'($urandom_range(0, 7));
      else if (r == 3)
         dip = 32'hFFFF_FFFF;
      else if (r == 4)
         dip[7:0] = $urandom_range(0, 1) ? 8'hE7 : 8'hF0;
      send_request(2'($urandom_range(0, 3)), ($urandom_range(0, 9) != 0), dip,
                   16'($urandom), {16'($urandom), 32'($urandom)}, use_gap);
   endtask

   // Two-phase register write; the register takes the value at the access edge.
   task automatic csr_write(input int idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_LOCAL_IP:  own_ip   = value[31:0];
         CSR_LOCAL_MAC: own_mac  = value[47:0];
         CSR_BUS_MODE:  bus_mode = value[2:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Drop valid and let every expected word come out before touching the registers.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (header_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Receiver: bursts of ready with random stalls, plus one long hold-off on request.
   initial begin : receiver
      int n;
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 80)) @(posedge clock);
            n = idle_gap();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin : result_checker
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (header_words.size() == 0) begin
            report_mismatch("unexpected result word", 64'(rsp_tdata), '0);
         end else begin
            want = header_words.pop_front();
            words_checked++;
            if (rsp_tdata[7:0] !== want.hbyte)
               report_mismatch("header_byte", 64'(rsp_tdata[7:0]), 64'(want.hbyte));
            if (rsp_tdata[13:8] !== want.index)
               report_mismatch("byte_index", 64'(rsp_tdata[13:8]), 64'(want.index));
            if (rsp_tdata[21:14] !== want.enables)
               report_mismatch("enable_register", 64'(rsp_tdata[21:14]),
                               64'(want.enables));
            if (rsp_tdata[RSP_DATA_W-1:22] !== '0)
               report_mismatch("tdata fill bits", 64'(rsp_tdata[RSP_DATA_W-1:22]), '0);
            if (rsp_tuser !== want.hvalid)
               report_mismatch("header_valid", 64'(rsp_tuser), 64'(want.hvalid));
            if (rsp_tlast !== want.last)
               report_mismatch("last_of_run", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // With the local IP still zero after reset, every request only clears its bit.
   task automatic test_without_local_ip();
      int s;
      for (s = 0; s < 4; s++)
         send_request(2'(s), 1'b1, $urandom, 16'($urandom), {16'($urandom), 32'($urandom)},
                      1'b1);
      send_request(2'd0, 1'b0, $urandom, 16'($urandom), '0, 1'b1);
      wait_drained();
   endtask

   // Address kinds at their edges, port and MAC extremes, enables and disables.
   task automatic test_directed_headers();
      csr_write(CSR_LOCAL_IP, '1);
      csr_write(CSR_LOCAL_MAC, '1);
      csr_write(CSR_BUS_MODE, '1);
      send_request(2'd0, 1'b1, 32'h0403_02E8, 16'h0000, 48'h0, 1'b1);         // 232.x multicast
      send_request(2'd1, 1'b1, 32'hFFFF_FFEF, 16'hFFFF, '1, 1'b1);            // 239.x, bit 7 set
      send_request(2'd2, 1'b1, 32'hFFFF_FFFF, 16'h1234, 48'hA5A5_5A5A_0F0F, 1'b1); // broadcast
      send_request(2'd3, 1'b1, 32'h0403_02E7, 16'h8001, 48'h1234_5678_9ABC, 1'b1); // unicast
      send_request(2'd0, 1'b1, 32'h0403_02F0, 16'h00FF, 48'h5A5A_A5A5_F0F0, 1'b1); // unicast
      send_request(2'd1, 1'b1, 32'hFFFF_FFFE, 16'hFF00, 48'h0F0F_0F0F_0F0F, 1'b1);
      send_request(2'd2, 1'b1, 32'h7FFF_FFFF, 16'h7FFF, 48'h8000_0000_0001, 1'b1);
      send_request(2'd3, 1'b1, 32'h0000_0000, 16'h0000, '1, 1'b1);
      send_request(2'd1, 1'b0, $urandom, 16'($urandom), '0, 1'b1);
      send_request(2'd2, 1'b0, $urandom, 16'($urandom), '0, 1'b1);            // mode nibble stays
      send_request(2'd3, 1'b0, $urandom, 16'($urandom), '0, 1'b1);
      send_request(2'd0, 1'b0, $urandom, 16'($urandom), '0, 1'b1);
      wait_drained();
      csr_write(CSR_LOCAL_IP, 64'h0000_0000_0000_0001);
      csr_write(CSR_LOCAL_MAC, '0);
      csr_write(CSR_BUS_MODE, '0);
      send_request(2'd2, 1'b1, 32'h80FF_00E8, 16'h2AF8, '1, 1'b1);
      send_request(2'd0, 1'b1, $urandom, 16'($urandom), {16'($urandom), 32'($urandom)}, 1'b1);
      send_request(2'd0, 1'b1, $urandom, 16'($urandom), {16'($urandom), 32'($urandom)}, 1'b0);
      send_request(2'd3, 1'b0, $urandom, 16'($urandom), '0, 1'b0);
      wait_drained();
   endtask

   // Step through every bus mode on the debug stream, then disable it.
   task automatic test_bus_modes();
      int m;
      csr_write(CSR_LOCAL_IP, {32'($urandom), 32'($urandom) | 32'h1});
      for (m = 0; m < 8; m++) begin
         csr_write(CSR_BUS_MODE, 64'(m));
         send_request(STREAM_DEBUG, 1'b1, $urandom, 16'($urandom),
                      {16'($urandom), 32'($urandom)}, 1'b1);
         wait_drained();
      end
      send_request(STREAM_DEBUG, 1'b0, $urandom, 16'($urandom), '0, 1'b1);
      wait_drained();
   endtask

   // A write past the last register must leave the header unchanged.
   task automatic test_spare_register();
      csr_write(CSR_SPARE_INDEX, {32'($urandom), 32'($urandom)});
      send_request(2'd1, 1'b1, $urandom, 16'($urandom), {16'($urandom), 32'($urandom)}, 1'b1);
      wait_drained();
   endtask

   // Hold the receiver off while requests keep coming, so the input backs up.
   task automatic test_output_backpressure();
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      repeat (8) send_random_request(1'b0);
      wait_drained();
   endtask

   // Random traffic over several setups, one with the local IP cleared.
   task automatic test_random_traffic();
      int phase;
      int count;
      for (phase = 0; phase < 6; phase++) begin
         count = 70;
         case (phase)
            1: begin
               csr_write(CSR_LOCAL_IP, '1);
               csr_write(CSR_LOCAL_MAC, '0);
               csr_write(CSR_BUS_MODE, 64'd7);
            end
            2: begin
               csr_write(CSR_LOCAL_IP, '0);
               csr_write(CSR_LOCAL_MAC, {32'($urandom), 32'($urandom)});
               count = 15;
            end
            3: begin
               csr_write(CSR_LOCAL_IP, 64'd1);
               csr_write(CSR_LOCAL_MAC, '1);
               csr_write(CSR_BUS_MODE, '0);
            end
            default: begin
               csr_write(CSR_LOCAL_IP, {32'($urandom), 32'($urandom)});
               csr_write(CSR_LOCAL_MAC, {32'($urandom), 32'($urandom)});
               csr_write(CSR_BUS_MODE, {32'($urandom), 32'($urandom)});
            end
         endcase
         repeat (count) send_random_request(1'b1);
         wait_drained();
      end
   endtask

   initial begin
      // Hold reset, then run the tests in turn.
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_without_local_ip();
      test_directed_headers();
      test_bus_modes();
      test_spare_register();
      test_output_backpressure();
      test_random_traffic();
      // Give any stray word time to show up after the last expected one.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (header_words.size() != 0)
         report_mismatch("words never delivered", 64'(header_words.size()), '0);
      $display("Sent %0d requests (%0d header runs, %0d disable-only) over %0d register writes.",
               requests_sent, header_runs, disable_words, csr_writes);
      $display("Checked %0d result words; %0d mismatches.", words_checked, error_count);
      if (error_count == 0) begin
         $display("udp_stream_header_builder verification clean");
      end else begin
         $display("udp_stream_header_builder verification failed");
      end
      $finish;
   end

endmodule
